// ===== sv/websocket_frame_deframer_top_defines.svh =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer: assertion macros
// Shared concurrent-assertion shorthands, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSDF_ASSERT_IMPL(lbl, rstn, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wsdf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSDF_ASSERT_NEXT(lbl, rstn, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wsdf assertion failed");

`endif

// ===== sv/wsdf_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer package
// Status codes, header constants and the queue record shared by all modules.
// ----------------------------------------------------------------------------
package wsdf_pkg;

    typedef enum logic [2:0] {
        ST_TEXT       = 3'd0,
        ST_BINARY     = 3'd1,
        ST_CLOSE      = 3'd2,
        ST_PING       = 3'd3,
        ST_PONG       = 3'd4,
        ST_INCOMPLETE = 3'd5,
        ST_ERROR      = 3'd6
    } wsdf_status_t;

    localparam logic [3:0]  OP_TEXT      = 4'h1;
    localparam logic [3:0]  OP_BINARY    = 4'h2;
    localparam logic [3:0]  OP_CLOSE     = 4'h8;
    localparam logic [3:0]  OP_PING      = 4'h9;
    localparam logic [3:0]  OP_PONG      = 4'hA;

    localparam logic [6:0]  LEN_CODE_16  = 7'h7E;
    localparam logic [6:0]  LEN_CODE_64  = 7'h7F;
    localparam int          POS_W        = 17;
    localparam logic [16:0] POS_MAX      = 17'h1FFFF;
    localparam int          TDATA_W      = 32;

    // One queue entry: what a single input word produced.
    typedef struct packed {
        logic         has_payload;
        logic [7:0]   payload_byte;
        logic         has_status;
        wsdf_status_t status;
        logic [15:0]  payload_length;
    } wsdf_rec_t;

    typedef struct packed {
        logic         ok;
        wsdf_status_t st;
    } wsdf_op_t;

    function automatic wsdf_op_t opcode_map(input logic [3:0] op);
        wsdf_op_t r;
        r.ok = 1'b1;
        case (op)
            OP_TEXT:   r.st = ST_TEXT;
            OP_BINARY: r.st = ST_BINARY;
            OP_CLOSE:  r.st = ST_CLOSE;
            OP_PING:   r.st = ST_PING;
            OP_PONG:   r.st = ST_PONG;
            default: begin
                r.ok = 1'b0;
                r.st = ST_ERROR;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== sv/wsdf_parser.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer: header parser (front end)
// Tracks the byte position, checks the header, captures length and key,
// unmasks payload words and builds the end-of-buffer status.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_top_defines.svh"

module wsdf_parser
    import wsdf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tlast,    // last_byte
    input  logic       q_full,
    output logic       push,
    output wsdf_rec_t  push_rec
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       hf_reg, hf_next;
    logic [6:0]       slc_reg, slc_next;
    logic [15:0]      ext_reg, ext_next;
    logic [31:0]      key_reg, key_next;
    logic             herr_reg, herr_next;

    logic             accept;
    logic             is126;
    logic [POS_W-1:0] hdr;
    logic [POS_W-1:0] body;
    logic [POS_W-1:0] body_end;
    logic [POS_W-1:0] len17;
    logic [1:0]       kidx;
    logic [7:0]       kbyte;
    wsdf_op_t         op_now;
    wsdf_op_t         op_last;
    logic             n_is126;
    logic [POS_W-1:0] n_len;
    logic [POS_W-1:0] n_need;
    wsdf_rec_t        rec;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    assign is126    = (slc_reg == LEN_CODE_16);
    assign hdr      = is126 ? POS_W'(4) : POS_W'(2);
    assign body     = hdr + POS_W'(4);
    assign len17    = is126 ? {1'b0, ext_reg} : POS_W'(slc_reg);
    assign body_end = body + len17;
    assign kidx     = pos_reg[1:0] - hdr[1:0];
    assign op_now   = opcode_map(hf_reg[3:0]);

    always_comb begin
        case (kidx)
            2'd0:    kbyte = key_reg[31:24];
            2'd1:    kbyte = key_reg[23:16];
            2'd2:    kbyte = key_reg[15:8];
            default: kbyte = key_reg[7:0];
        endcase
    end

    always_comb begin
        pos_next  = pos_reg;
        hf_next   = hf_reg;
        slc_next  = slc_reg;
        ext_next  = ext_reg;
        key_next  = key_reg;
        herr_next = herr_reg;
        rec       = '0;
        op_last   = opcode_map(hf_reg[3:0]);
        n_is126   = 1'b0;
        n_len     = '0;
        n_need    = '0;

        if (accept) begin
            if (pos_reg == '0) begin
                hf_next = s_tdata;
            end else if (pos_reg == POS_W'(1)) begin
                slc_next  = s_tdata[6:0];
                herr_next = (hf_reg[6:4] != 3'b000) || !hf_reg[7] || !s_tdata[7]
                            || !op_now.ok;
            end else if (!herr_reg && slc_reg != LEN_CODE_64) begin
                if (is126 && pos_reg < POS_W'(4)) begin
                    ext_next = {ext_reg[7:0], s_tdata};
                end
                if (pos_reg >= hdr && pos_reg < body) begin
                    case (kidx)
                        2'd0:    key_next[31:24] = s_tdata;
                        2'd1:    key_next[23:16] = s_tdata;
                        2'd2:    key_next[15:8]  = s_tdata;
                        default: key_next[7:0]   = s_tdata;
                    endcase
                end else if (pos_reg >= body && pos_reg < body_end) begin
                    rec.has_payload  = 1'b1;
                    rec.payload_byte = s_tdata ^ kbyte;
                end
            end

            if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + POS_W'(1);
            end

            // End of buffer: judge with the state as updated by this word.
            if (s_tlast) begin
                op_last = opcode_map(hf_next[3:0]);
                n_is126 = (slc_next == LEN_CODE_16);
                n_len   = n_is126 ? {1'b0, ext_next} : POS_W'(slc_next);
                n_need  = n_len + (n_is126 ? POS_W'(8) : POS_W'(6));
                rec.has_status = 1'b1;
                if (pos_next < POS_W'(2)) begin
                    rec.status = ST_INCOMPLETE;
                end else if (herr_next) begin
                    rec.status = ST_ERROR;
                end else if (slc_next == LEN_CODE_64) begin
                    rec.status = (pos_next < POS_W'(10)) ? ST_INCOMPLETE : ST_ERROR;
                end else if (n_is126 && pos_next < POS_W'(4)) begin
                    rec.status = ST_INCOMPLETE;
                end else if (n_len != '0 && n_need > pos_next) begin
                    rec.status = ST_INCOMPLETE;
                end else begin
                    rec.status         = op_last.st;
                    rec.payload_length = n_len[15:0];
                end
                // Return to the idle header state for the next buffer.
                pos_next  = '0;
                hf_next   = '0;
                slc_next  = '0;
                ext_next  = '0;
                key_next  = '0;
                herr_next = 1'b0;
            end
        end
    end

    assign push     = accept && (rec.has_payload || rec.has_status);
    assign push_rec = rec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            hf_reg   <= '0;
            slc_reg  <= '0;
            ext_reg  <= '0;
            key_reg  <= '0;
            herr_reg <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            hf_reg   <= hf_next;
            slc_reg  <= slc_next;
            ext_reg  <= ext_next;
            key_reg  <= key_next;
            herr_reg <= herr_next;
        end
    end

    `WSDF_ASSERT_NEXT(a_last_rewinds, aresetn, accept && s_tlast, pos_reg == '0)
    `WSDF_ASSERT_IMPL(a_err_after_hdr, aresetn, herr_reg, pos_reg >= POS_W'(2))

endmodule

// ===== sv/wsdf_queue.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer: record queue
// Small register FIFO between the parser and the emitter.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_top_defines.svh"

module wsdf_queue
    import wsdf_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  wsdf_rec_t push_rec,
    input  logic      pop,
    output wsdf_rec_t head,
    output logic      empty,
    output logic      full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wsdf_rec_t     mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_pop;

    assign empty  = (cnt_reg == '0);
    assign full   = (cnt_reg == CW'(DEPTH));
    assign head   = mem_reg[rd_reg];
    assign do_pop = pop && !empty;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
        end
        case ({push, do_pop})
            2'b10:   cnt_next = cnt_reg + CW'(1);
            2'b01:   cnt_next = cnt_reg - CW'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_rec;
        end
    end

    `WSDF_ASSERT_IMPL(a_no_overflow, aresetn, push, !full)
    `WSDF_ASSERT_IMPL(a_count_range, aresetn, 1'b1, cnt_reg <= CW'(DEPTH))

endmodule

// ===== sv/wsdf_emitter.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer: result emitter (back end)
// Splits each queue record into payload and status words behind an
// output register.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_top_defines.svh"

module wsdf_emitter
    import wsdf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  wsdf_rec_t          head,
    input  logic               q_empty,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [7:0] payload_byte, [10:8] status,
                                          // [26:11] payload_length, rest zero
    output logic               m_tlast    // kind
);

    logic               valid_reg, valid_next;
    logic               last_reg, last_next;
    logic [TDATA_W-1:0] data_reg, data_next;
    logic               phase_reg, phase_next;
    logic               load;

    assign load = !q_empty && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        last_next  = last_reg;
        data_next  = data_reg;
        phase_next = phase_reg;
        pop        = 1'b0;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            if (!phase_reg && head.has_payload) begin
                last_next = 1'b0;
                data_next = TDATA_W'(head.payload_byte);
                if (head.has_status) begin
                    phase_next = 1'b1;
                end else begin
                    pop = 1'b1;
                end
            end else begin
                last_next  = 1'b1;
                data_next  = TDATA_W'({head.payload_length, head.status, 8'h00});
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg <= last_next;
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = data_reg;

    `WSDF_ASSERT_IMPL(a_phase_holds_pair, aresetn, phase_reg,
        !q_empty && head.has_payload && head.has_status)

endmodule

// ===== sv/websocket_frame_deframer_top.sv =====
// Flow: an accepted input word is stored as a record in the queue, and its result
// words then pass the output register; a status word follows its payload word.
// Throughput: one input word per cycle while the queue has room; a payload word
// that also ends the buffer yields two output words, so it costs one extra slot,
// absorbed by the record queue (QUEUE_DEPTH entries) between front and back.
// Reset: aresetn is synchronous, active low; it clears parser state, queue
// pointers and the output valid.
// ----------------------------------------------------------------------------
// WebSocket frame deframer top level
// Parses one client-to-server frame per buffer, unmasks the payload and
// reports the frame type, incomplete or error on the buffer's last word.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top
    import wsdf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Input stream: raw frame bytes.
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // last_byte
    // Result stream: payload words, then one status word per buffer.
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [7:0] payload_byte, [10:8] status,
                                          // [26:11] payload_length, [31:27] zero
    output logic               m_tlast    // kind: 0 payload word, 1 status word
);

    // Front end to queue.
    logic      push;
    wsdf_rec_t push_rec;
    logic      q_full;

    // Queue to back end.
    wsdf_rec_t head;
    logic      q_empty;
    logic      pop;

    // Front end: accept a word every cycle the queue has room, track the
    // header, and push one record per word that produces anything.
    wsdf_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_rec (push_rec)
    );

    // Decouple the two sides so output stalls do not stall parsing at once.
    wsdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Back end: drain records, emit payload first and status after it.
    wsdf_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
